// File: sv/tcf_pkg.sv
// Package for the tilt complementary filter: widths, constants and the CORDIC angle table.
package tcf_pkg;

  localparam int CORDIC_STEPS        = 16;
  localparam int ANGLE_FRACTION_BITS = 16;
  localparam int ACCEL_BITS          = 16;

  localparam int ANGLE_W   = 25;
  localparam int WEIGHT_W  = 16;
  localparam int PERIOD_W  = 20;
  localparam int RATE_W    = 20;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd1;

  localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RESET   = 16'd9830;
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 20'd10503;

  localparam logic signed [ANGLE_W-1:0] NINETY   = ANGLE_W'(90 <<< ANGLE_FRACTION_BITS);
  localparam logic signed [ANGLE_W-1:0] ONE_EIGHTY = ANGLE_W'(180 <<< ANGLE_FRACTION_BITS);

  // atan(2^-i) in degrees, rounded to 2^-ANGLE_FRACTION_BITS (values for 16 fraction bits).
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ANGLE_W-1:0] v;
    case (i)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/tilt_complementary_filter.sv
// Tilt complementary filter: iterative CORDIC tilt, bit-serial gyro step and blend.
// Sequence: the accepting edge starts a phase of CORDIC and the serial gyro multiply (the last
// partial product lands before the blend operands are loaded), then the serial blend runs, then
// the output is loaded. A new input is taken only once the previous item has left the sequencer;
// a waiting result does not stop the next input from being taken, it only holds the next result.
// Reset (rst, synchronous, active high) clears the state, the stored angles and restores the registers.
module tilt_complementary_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   accel_valid,
  input  logic signed [tcf_pkg::ACCEL_BITS-1:0]  accel_y,
  input  logic signed [tcf_pkg::ACCEL_BITS-1:0]  accel_z,
  input  logic                                   gyro_valid,
  input  logic signed [tcf_pkg::RATE_W-1:0]      gyro_rate,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tcf_pkg::ANGLE_W-1:0]     tilt_angle,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tcf_pkg::CFG_DAT_W-1:0]          cfg_data
);
  import tcf_pkg::*;

  // The CORDIC and the gyro multiply share one phase, which runs on past the longer of the
  // two so that the final partial product is in the accumulator when the blend is loaded.
  localparam int PHASE_LEN = ((CORDIC_STEPS > PERIOD_W) ? CORDIC_STEPS : PERIOD_W) + 1;
  localparam int BLEND_LEN = WEIGHT_W + 1;
  localparam int CNT_W     = $clog2(PHASE_LEN + 1);
  localparam int CX_W      = ACCEL_BITS + 20;
  localparam int PROD_W    = RATE_W + PERIOD_W + 1;
  localparam int SH        = 28 - ANGLE_FRACTION_BITS;
  localparam int STEP_W    = PROD_W - SH;
  localparam int SUM_W     = STEP_W + 2;
  localparam int ACC_W     = SUM_W + BLEND_LEN + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_BLEND = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;

  logic [WEIGHT_W-1:0] gyro_weight;
  logic [PERIOD_W-1:0] sample_period;

  logic signed [ANGLE_W-1:0] prior_angle;
  logic signed [ANGLE_W-1:0] held_accel_angle;

  // Captured sample flags.
  logic av;
  logic gv;
  logic fixed_angle;
  logic signed [ANGLE_W-1:0] fixed_value;

  // CORDIC working registers.
  logic signed [CX_W-1:0]    cx;
  logic signed [CX_W-1:0]    cy;
  logic signed [ANGLE_W-1:0] cacc;

  // Serial gyro multiply: the period shifts right, the rate shifts left.
  logic [PERIOD_W-1:0]      mper;
  logic signed [PROD_W-1:0] mrate;
  logic signed [PROD_W-1:0] prod;

  // Serial blend.
  logic [BLEND_LEN-1:0]    kreg;
  logic [BLEND_LEN-1:0]    kcreg;
  logic signed [ACC_W-1:0] aa;
  logic signed [ACC_W-1:0] hh;
  logic signed [ACC_W-1:0] bacc;

  logic signed [ANGLE_W-1:0] result;

  logic in_take;
  logic out_free;

  logic signed [CX_W-1:0]    dx;
  logic signed [CX_W-1:0]    dy;
  logic signed [ANGLE_W-1:0] cacc_next;
  logic signed [ANGLE_W-1:0] cord_angle;
  logic signed [ANGLE_W-1:0] accel_next;
  logic signed [PROD_W-1:0]  step_full;
  logic signed [STEP_W-1:0]  step;
  logic signed [SUM_W-1:0]   gsum;
  logic signed [ACC_W-1:0]   bsh;
  logic signed [CX_W-1:0]    y_ext;
  logic signed [CX_W-1:0]    z_ext;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign y_ext = CX_W'(accel_y);
  assign z_ext = CX_W'(accel_z);

  // One CORDIC rotation per cycle: the step index is the phase counter.
  always_comb begin
    dx = cy >>> cnt;
    dy = cx >>> cnt;
    if (cy >= 0) begin
      cacc_next = cacc + atan_entry(5'(cnt));
    end else begin
      cacc_next = cacc - atan_entry(5'(cnt));
    end
    if (cacc > NINETY) begin
      cord_angle = NINETY;
    end else if (cacc < -NINETY) begin
      cord_angle = -NINETY;
    end else begin
      cord_angle = cacc;
    end
    accel_next = fixed_angle ? fixed_value : cord_angle;
  end

  // The gyro step is rounded half up to the angle resolution.
  always_comb begin
    step_full = (prod + PROD_W'(1 <<< (SH - 1))) >>> SH;
    step      = gv ? STEP_W'(step_full) : '0;
    gsum      = SUM_W'(prior_angle) + SUM_W'(step);
    bsh       = bacc >>> 16;
    if (bsh > ACC_W'(ONE_EIGHTY)) begin
      result = ONE_EIGHTY;
    end else if (bsh < -ACC_W'(ONE_EIGHTY)) begin
      result = -ONE_EIGHTY;
    end else begin
      result = ANGLE_W'(bsh);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight   <= GYRO_WEIGHT_RESET;
      sample_period <= SAMPLE_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GYRO_WEIGHT:   gyro_weight   <= cfg_data[WEIGHT_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: capture, CORDIC with gyro multiply, serial blend, then hand over the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cnt              <= '0;
      prior_angle      <= '0;
      held_accel_angle <= '0;
      out_valid        <= 1'b0;
    end else begin
      // A new result is loaded only once the previous one has gone or is going now.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(PHASE_LEN - 1)) begin
            if (av) begin
              held_accel_angle <= accel_next;
            end
            state <= S_BLEND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLEND: begin
          if (cnt == CNT_W'(BLEND_LEN - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            prior_angle <= result;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          av          <= accel_valid;
          gv          <= gyro_valid;
          fixed_angle <= (accel_y == 0) || (accel_z == 0);
          if (accel_y == 0) begin
            fixed_value <= '0;
          end else if (accel_y > 0) begin
            fixed_value <= NINETY;
          end else begin
            fixed_value <= -NINETY;
          end
          // Fold negative z onto the right half plane: atan(y/z) rather than atan2.
          if (accel_z < 0) begin
            cx <= (-z_ext) <<< 16;
            cy <= (-y_ext) <<< 16;
          end else begin
            cx <= z_ext <<< 16;
            cy <= y_ext <<< 16;
          end
          cacc  <= '0;
          mper  <= sample_period;
          mrate <= PROD_W'(gyro_rate);
          prod  <= '0;
        end
      end
      S_MUL: begin
        if (cnt < CNT_W'(CORDIC_STEPS)) begin
          if (cy >= 0) begin
            cx <= cx + dx;
            cy <= cy - dy;
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
          end
          cacc <= cacc_next;
        end
        if (cnt < CNT_W'(PERIOD_W)) begin
          if (mper[0]) begin
            prod <= prod + mrate;
          end
          mper  <= mper >> 1;
          mrate <= mrate <<< 1;
        end
        if (cnt == CNT_W'(PHASE_LEN - 1)) begin
          kreg  <= BLEND_LEN'(gyro_weight);
          kcreg <= BLEND_LEN'(17'd65536 - BLEND_LEN'(gyro_weight));
          aa    <= ACC_W'(gsum);
          hh    <= ACC_W'(av ? accel_next : held_accel_angle);
          bacc  <= ACC_W'(32768);
        end
      end
      S_BLEND: begin
        bacc  <= bacc + (kreg[0] ? aa : '0) + (kcreg[0] ? hh : '0);
        kreg  <= kreg >> 1;
        kcreg <= kcreg >> 1;
        aa    <= aa <<< 1;
        hh    <= hh <<< 1;
      end
      S_DONE: begin
        if (out_free) begin
          tilt_angle <= result;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tilt_angle <= ONE_EIGHTY) && (tilt_angle >= -ONE_EIGHTY))
    else $error("tilt angle beyond saturation limit");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_BLEND) |-> in_stall)
    else $error("input taken while an item is in progress");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result presented without a finished blend");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_MUL) && (cnt == '0))
    else $error("accepted transaction did not start the sequencer");
`endif

endmodule
